// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ===== rtl/core/xcr_pkg.sv =====
// Shared types and constants of the XMODEM-CRC receiver.
`timescale 1ns / 1ps

package xcr_pkg;

    localparam int DATA_BYTES_DEF = 128;

    // request codes
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // line characters
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_C   = 8'h43;

    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_INIT   = 16'h0000;
    localparam logic [8:0]  NUM_SUM_OK = 9'd255;

    // verdict codes
    localparam logic [1:0] VERDICT_NONE   = 2'd0;
    localparam logic [1:0] VERDICT_COMMIT = 2'd1;
    localparam logic [1:0] VERDICT_DROP   = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_RUN     = 2'd0;
    localparam logic [1:0] STATUS_EOT_OK  = 2'd1;
    localparam logic [1:0] STATUS_FAILED  = 2'd2;
    localparam logic [1:0] STATUS_DRAINED = 2'd3;

    // phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_RECV  = 2'd1;
    localparam logic [1:0] PH_DRAIN = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_RETRY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PKT_RETRY   = 2'd2;

    localparam logic [15:0] TIMEOUT_RST     = 16'd1000;
    localparam logic [7:0]  START_RETRY_RST = 8'd10;
    localparam logic [7:0]  PKT_RETRY_RST   = 8'd10;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [7:0]  start_retries;
        logic [7:0]  packet_retries;
    } cfg_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [6:0] payload_index;
        logic [1:0] verdict;
        logic [1:0] status;
    } result_t;

endpackage

// ===== rtl/core/xcr_crc.sv =====
// CRC-16-CCITT byte update, MSB first.
`timescale 1ns / 1ps

module xcr_crc
    import xcr_pkg::*;
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);

    always_comb begin
        crc_out = crc_in ^ {data_in, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc_out[15]) begin
                crc_out = {crc_out[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc_out = {crc_out[14:0], 1'b0};
            end
        end
    end

endmodule

// ===== rtl/core/xcr_cfg.sv =====
// Configuration registers of the receiver.
`timescale 1ns / 1ps

module xcr_cfg
    import xcr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_TIMEOUT:     cfg_next.timeout_ticks  = cfg_data;
                CFG_START_RETRY: cfg_next.start_retries  = cfg_data[7:0];
                CFG_PKT_RETRY:   cfg_next.packet_retries = cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ticks  <= TIMEOUT_RST;
            cfg_reg.start_retries  <= START_RETRY_RST;
            cfg_reg.packet_retries <= PKT_RETRY_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/xcr_ctrl.sv =====
// Protocol state and per-request result logic.
`timescale 1ns / 1ps

module xcr_ctrl
    import xcr_pkg::*;
#(
    parameter int DATA_BYTES = DATA_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [1:0] req_type,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output result_t    res
);

    // wide enough for the last position and for a 7-bit payload index
    localparam int POS_W = ($clog2(DATA_BYTES + 5) > 7) ? $clog2(DATA_BYTES + 5) : 7;
    localparam logic [POS_W-1:0] POS_NUM   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_CMPL  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_DATA  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_CRC_H = POS_W'(3 + DATA_BYTES);

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_FAIL = 2'd1;
    localparam logic [1:0] KIND_EOT  = 2'd2;
    localparam logic [1:0] KIND_GOOD = 2'd3;

    logic [1:0]       phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             soh_reg, soh_next;
    logic [7:0]       num_reg, num_next;
    logic [8:0]       sum_reg, sum_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       crc_high_reg, crc_high_next;
    logic [7:0]       exp_reg, exp_next;
    logic [7:0]       retries_reg, retries_next;
    logic             fad_reg, fad_next;
    logic [15:0]      idle_reg, idle_next;

    logic [15:0]      crc_upd;
    logic [POS_W-1:0] data_off;
    logic [1:0]       kind;
    logic             had_payload;
    logic             crc_ok;
    logic             do_next;
    logic             do_begin;

    xcr_crc u_crc (
        .crc_in  (crc_reg),
        .data_in (rx_byte),
        .crc_out (crc_upd)
    );

    assign data_off = pos_reg - POS_DATA;

    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        soh_next      = soh_reg;
        num_next      = num_reg;
        sum_next      = sum_reg;
        crc_next      = crc_reg;
        crc_high_next = crc_high_reg;
        exp_next      = exp_reg;
        retries_next  = retries_reg;
        fad_next      = fad_reg;
        idle_next     = idle_reg;
        res           = '0;
        kind          = KIND_NONE;
        do_next       = 1'b0;
        do_begin      = 1'b0;
        had_payload   = pos_reg > POS_DATA;
        crc_ok        = soh_reg && (sum_reg == NUM_SUM_OK) && (crc_reg == {crc_high_reg, rx_byte});

        case (req_type)
            REQ_START: begin
                if (phase_reg == PH_RECV && had_payload) begin
                    res.verdict = VERDICT_DROP;
                end
                exp_next     = 8'd1;
                fad_next     = 1'b0;
                retries_next = cfg.start_retries;
                phase_next   = PH_RECV;
                do_next      = 1'b1;
            end
            REQ_BYTE: begin
                if (phase_reg != PH_IDLE) begin
                    idle_next = '0;
                    if (pos_reg == '0) begin
                        if (rx_byte == CH_EOT) begin
                            kind = KIND_EOT;
                        end else begin
                            soh_next = (rx_byte == CH_SOH);
                            pos_next = pos_reg + POS_NUM;
                        end
                    end else if (pos_reg == POS_NUM) begin
                        num_next = rx_byte;
                        sum_next = {1'b0, rx_byte};
                        pos_next = pos_reg + POS_NUM;
                    end else if (pos_reg == POS_CMPL) begin
                        sum_next = sum_reg + {1'b0, rx_byte};
                        pos_next = pos_reg + POS_NUM;
                    end else if (pos_reg < POS_CRC_H) begin
                        crc_next = crc_upd;
                        if (phase_reg == PH_RECV) begin
                            res.payload_valid = 1'b1;
                            res.payload_byte  = rx_byte;
                            res.payload_index = data_off[6:0];
                        end
                        pos_next = pos_reg + POS_NUM;
                    end else if (pos_reg == POS_CRC_H) begin
                        crc_high_next = rx_byte;
                        pos_next      = pos_reg + POS_NUM;
                    end else begin
                        kind = crc_ok ? KIND_GOOD : KIND_FAIL;
                    end
                end
            end
            REQ_TICK: begin
                if (phase_reg != PH_IDLE) begin
                    if (idle_reg != 16'hFFFF) begin
                        idle_next = idle_reg + 16'd1;
                    end
                    if (idle_next >= cfg.timeout_ticks) begin
                        kind = KIND_FAIL;
                    end
                end
            end
            default: ;
        endcase

        if (kind != KIND_NONE) begin
            if (phase_reg == PH_RECV) begin
                case (kind)
                    KIND_EOT: begin
                        res.tx_valid = 1'b1;
                        res.tx_byte  = CH_ACK;
                        res.status   = STATUS_EOT_OK;
                        if (retries_next == '0) begin
                            phase_next = PH_IDLE;
                        end else begin
                            retries_next = retries_next - 8'd1;
                            phase_next   = PH_DRAIN;
                            do_begin     = 1'b1;
                        end
                    end
                    KIND_FAIL: begin
                        if (fad_reg) begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = CH_NAK;
                        end
                        if (had_payload) begin
                            res.verdict = VERDICT_DROP;
                        end
                        do_next = 1'b1;
                    end
                    default: begin
                        // complete packet with good framing and CRC
                        res.tx_valid = 1'b1;
                        if (num_reg == exp_reg - 8'd1) begin
                            res.tx_byte = CH_ACK;
                            res.verdict = VERDICT_DROP;
                        end else if (num_reg != exp_reg) begin
                            res.tx_byte = CH_NAK;
                            res.verdict = VERDICT_DROP;
                        end else begin
                            res.tx_byte  = CH_ACK;
                            res.verdict  = VERDICT_COMMIT;
                            exp_next     = exp_reg + 8'd1;
                            retries_next = cfg.packet_retries;
                            fad_next     = 1'b1;
                        end
                        do_next = 1'b1;
                    end
                endcase
            end else begin
                if (kind == KIND_FAIL) begin
                    phase_next = PH_IDLE;
                    res.status = STATUS_DRAINED;
                end else begin
                    if (kind == KIND_EOT) begin
                        res.tx_valid = 1'b1;
                        res.tx_byte  = CH_ACK;
                    end
                    if (retries_next == '0) begin
                        phase_next = PH_IDLE;
                        res.status = STATUS_DRAINED;
                    end else begin
                        retries_next = retries_next - 8'd1;
                        do_begin     = 1'b1;
                    end
                end
            end
        end

        // next receive attempt; 'C' only before the first committed packet and when nothing else is being sent
        if (do_next) begin
            if (retries_next == '0) begin
                phase_next = PH_IDLE;
                res.status = STATUS_FAILED;
            end else begin
                retries_next = retries_next - 8'd1;
                if (!fad_next && !res.tx_valid) begin
                    res.tx_valid = 1'b1;
                    res.tx_byte  = CH_C;
                end
                do_begin = 1'b1;
            end
        end

        if (do_begin) begin
            pos_next      = '0;
            idle_next     = '0;
            crc_next      = CRC_INIT;
            soh_next      = 1'b0;
            num_next      = '0;
            sum_next      = '0;
            crc_high_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            pos_reg      <= '0;
            soh_reg      <= 1'b0;
            num_reg      <= '0;
            sum_reg      <= '0;
            crc_reg      <= CRC_INIT;
            crc_high_reg <= '0;
            exp_reg      <= 8'd1;
            retries_reg  <= '0;
            fad_reg      <= 1'b0;
            idle_reg     <= '0;
        end else if (step) begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            soh_reg      <= soh_next;
            num_reg      <= num_next;
            sum_reg      <= sum_next;
            crc_reg      <= crc_next;
            crc_high_reg <= crc_high_next;
            exp_reg      <= exp_next;
            retries_reg  <= retries_next;
            fad_reg      <= fad_next;
            idle_reg     <= idle_next;
        end
    end

endmodule

// ===== rtl/core/xmodem_crc_receiver_unit.sv =====
// XMODEM-CRC receiver: top level with input and result registers.
//
// Receive side of an XMODEM-CRC transfer. Each input transfer is one request:
// start (tuser 0), a byte from the line (tuser 1, byte in tdata) or a timer
// tick (tuser 2). Every request yields exactly one result transfer holding the
// control byte to send ('C', ACK or NAK), the payload byte as it arrives with
// its index (tentative), a commit/drop verdict at each packet end and a
// transfer status. Requests are taken one per clock unless m_tready stalls the
// result register: the request register feeds one pass of control logic
// (framing checks, byte-wide CRC-16 update, retry and phase handling) that
// writes the result register. The only stall source is m_tready.
// Configuration writes are meant for idle periods; no buffer of packet data
// is kept.
`timescale 1ns / 1ps

module xmodem_crc_receiver_unit
    import xcr_pkg::*;
#(
    parameter int DATA_BYTES = DATA_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    input  logic [1:0]           s_tuser,   // [1:0] req_type
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] tx_valid, [8:1] tx_byte, [9] payload_valid, [17:10] payload_byte,
    // [24:18] payload_index, [26:25] verdict, [28:27] status, [31:29] zero
    output logic [31:0]          m_tdata,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    cfg_t    cfg;
    result_t res;

    // request register
    logic       in_valid_reg, in_valid_next;
    logic [1:0] in_req_reg;
    logic [7:0] in_byte_reg;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg;

    logic advance;
    logic s_xfer;

    // a request is processed when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    xcr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    xcr_ctrl #(
        .DATA_BYTES (DATA_BYTES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .req_type (in_req_reg),
        .rx_byte  (in_byte_reg),
        .cfg      (cfg),
        .res      (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_req_reg  <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            out_data_reg <= {3'b000, res.status, res.verdict, res.payload_index,
                             res.payload_byte, res.payload_valid, res.tx_byte,
                             res.tx_valid};
        end
    end

endmodule

// ===== rtl/core/xcr_checker.sv =====
// Port-level checks of the receiver and their bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xcr_checker
    import xcr_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    logic [7:0] tx_byte_f;
    logic       tx_code_ok;

    assign tx_byte_f  = m_tdata[8:1];
    assign tx_code_ok = (tx_byte_f == CH_C) || (tx_byte_f == CH_ACK) || (tx_byte_f == CH_NAK);

    // a sent control byte is one of the three protocol characters
    `ASSERT_IMPL(a_tx_code, aclk, aresetn, m_tvalid && m_tdata[0], tx_code_ok)

    // no control byte means a zero tx byte field
    `ASSERT_IMPL(a_tx_idle, aclk, aresetn, m_tvalid && !m_tdata[0], tx_byte_f == 8'h00)

    // no payload means zero byte and index fields
    `ASSERT_IMPL(a_pl_idle, aclk, aresetn, m_tvalid && !m_tdata[9], m_tdata[24:10] == 15'h0000)

    // a stalled result holds
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind xmodem_crc_receiver_unit xcr_checker u_xcr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
